### hw/rtl/gamrp_pkg.sv
// Shared constants, types and the letter-chain matcher for the GPS/modem response parser.
`timescale 1ns / 1ps
`default_nettype none
package gamrp_pkg;

   localparam int GPS_BUF_DEPTH_DEFAULT   = 64;
   localparam int FRAME_BUF_DEPTH_DEFAULT = 32;
   localparam int IP_TEXT_LEN_DEFAULT     = 15;

   localparam int EVENTS_W   = 8;
   localparam int BYTE_W     = 8;
   localparam int GPS_SLOT_W = 6;
   localparam int FRM_SLOT_W = 5;
   localparam int IP_SLOT_W  = 4;
   localparam int MATCH_W    = 8;

   // Characters the parser reacts to
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
   localparam logic [7:0] CHAR_STAR   = 8'h2A;  // '*'
   localparam logic [7:0] CHAR_PROMPT = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_L      = 8'h4C;  // 'L'
   localparam logic [7:0] CHAR_O      = 8'h4F;  // 'O'
   localparam logic [7:0] CHAR_K      = 8'h4B;  // 'K'
   localparam logic [7:0] CHAR_G      = 8'h47;  // 'G'
   localparam logic [7:0] CHAR_P      = 8'h50;  // 'P'
   localparam logic [7:0] CHAR_R      = 8'h52;  // 'R'

   localparam logic [0:8][7:0] SERVER_WORD = {8'h53, 8'h45, 8'h52, 8'h56, 8'h45,
                                              8'h52, 8'h20, 8'h4F, 8'h4B};
   localparam logic [0:8][7:0] REMOTE_WORD = {8'h52, 8'h45, 8'h4D, 8'h4F, 8'h54,
                                              8'h45, 8'h20, 8'h49, 8'h50};

   // Event bit positions
   localparam int EV_OK        = 0;
   localparam int EV_SERVER_OK = 1;
   localparam int EV_REMOTE_IP = 2;
   localparam int EV_GPS_END   = 3;
   localparam int EV_FRAME_END = 4;
   localparam int EV_PROMPT    = 5;
   localparam int EV_IP_DONE   = 6;
   localparam int EV_LOC_REQ   = 7;

   typedef enum logic [1:0] {
      HDR_IDLE,
      HDR_DOLLAR,
      HDR_G,
      HDR_P
   } hdr_state_type;

   // Sticky per-letter matcher; steps in letter order, so a letter may chain
   // off a flag set earlier in the same byte. Returns {done, flags}.
   function automatic logic [MATCH_W:0] chain_step(input logic [0:8][7:0] word,
                                                   input logic [MATCH_W-1:0] flags,
                                                   input logic [7:0] c);
      logic [MATCH_W-1:0] f;
      logic               done;
      f    = flags;
      done = 1'b0;
      if (c == word[0]) f[0] = 1'b1;
      for (int i = 1; i < MATCH_W; i++) begin
         if (c == word[i] && f[i-1]) begin
            f[i]   = 1'b1;
            f[i-1] = 1'b0;
         end
      end
      if (c == word[8] && f[MATCH_W-1]) begin
         f[MATCH_W-1] = 1'b0;
         done         = 1'b1;
      end
      return {done, f};
   endfunction

endpackage
`default_nettype wire

### hw/rtl/gamrp_if.sv
// Valid/ready channel interfaces for parser input bytes and parser results.
`timescale 1ns / 1ps
`default_nettype none
interface gamrp_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;
   logic       gps_source;

   modport source (output valid, output mode, output rx_byte, output gps_source,
                   input ready);
   modport sink   (input valid, input mode, input rx_byte, input gps_source,
                   output ready);
endinterface

interface gamrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] events;
   logic [7:0] echo_byte;
   logic       gps_write;
   logic [5:0] gps_slot;
   logic       frame_write;
   logic [4:0] frame_slot;
   logic       ip_write;
   logic [3:0] ip_slot;

   modport source (output valid, output events, output echo_byte, output gps_write,
                   output gps_slot, output frame_write, output frame_slot,
                   output ip_write, output ip_slot, input ready);
   modport sink   (input valid, input events, input echo_byte, input gps_write,
                   input gps_slot, input frame_write, input frame_slot,
                   input ip_write, input ip_slot, output ready);
endinterface
`default_nettype wire

### hw/rtl/gps_and_modem_response_parser_top.sv
// Top level of the GPS sentence / modem response parser.
`timescale 1ns / 1ps
`default_nettype none
// Each transfer on req_chan is one UART byte (or an arm command when mode is 1)
// and yields exactly one transfer on rsp_chan from a result register, carrying event
// flags and write slots for the sentence, kiosk frame and address text
// buffers. Throughput is one byte per cycle: all parsing is a single pass of
// logic into one result register, and a new byte is taken whenever that
// register is empty or being emptied in the same cycle. Write positions stop
// at their buffer depths; no buffer is overrun.
module gps_and_modem_response_parser_top
   import gamrp_pkg::*;
#(
   parameter int GPS_BUF_DEPTH   = GPS_BUF_DEPTH_DEFAULT,
   parameter int FRAME_BUF_DEPTH = FRAME_BUF_DEPTH_DEFAULT,
   parameter int IP_TEXT_LEN     = IP_TEXT_LEN_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gamrp_req_if.sink   req_chan,
   gamrp_rsp_if.source rsp_chan
);

   localparam int GPW = $clog2(GPS_BUF_DEPTH + 1);
   localparam int FPW = $clog2(FRAME_BUF_DEPTH + 1);

   logic accept;

   hdr_state_type hdr_state_ff, hdr_state_in;
   logic               gps_cap_ff, gps_cap_in;
   logic [GPW-1:0]     gps_pos_ff, gps_pos_in;
   logic               ok_half_ff, ok_half_in;
   logic [MATCH_W-1:0] server_ff, server_in;
   logic [MATCH_W-1:0] remote_ff, remote_in;
   logic               frm_act_ff, frm_act_in;
   logic [FPW-1:0]     frm_pos_ff, frm_pos_in;
   logic               ip_act_ff, ip_act_in;
   logic [IP_SLOT_W-1:0] ip_pos_ff, ip_pos_in;

   logic                  rsp_valid_ff;
   logic [EVENTS_W-1:0]   events_ff, events_in;
   logic [BYTE_W-1:0]     echo_ff, echo_in;
   logic                  gps_wr_ff, gps_wr_in;
   logic [GPS_SLOT_W-1:0] gps_slot_ff, gps_slot_in;
   logic                  frm_wr_ff, frm_wr_in;
   logic [FRM_SLOT_W-1:0] frm_slot_ff, frm_slot_in;
   logic                  ip_wr_ff, ip_wr_in;
   logic [IP_SLOT_W-1:0]  ip_slot_ff, ip_slot_in;

   logic [7:0]         c;
   logic               gps;
   logic [MATCH_W:0]   server_res;
   logic [MATCH_W:0]   remote_res;
   logic [IP_SLOT_W:0] ip_next;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign c   = req_chan.rx_byte;
   assign gps = req_chan.gps_source;

   assign server_res = chain_step(SERVER_WORD, server_ff, c);
   assign remote_res = chain_step(REMOTE_WORD, remote_ff, c);
   assign ip_next    = {1'b0, ip_pos_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_state_ff <= HDR_IDLE;
      end else if (accept) begin
         hdr_state_ff <= hdr_state_in;
      end
   end

   always_comb begin
      hdr_state_in = hdr_state_ff;
      gps_cap_in   = gps_cap_ff;
      gps_pos_in   = gps_pos_ff;
      ok_half_in   = ok_half_ff;
      server_in    = server_ff;
      remote_in    = remote_ff;
      frm_act_in   = frm_act_ff;
      frm_pos_in   = frm_pos_ff;
      ip_act_in    = ip_act_ff;
      ip_pos_in    = ip_pos_ff;
      events_in    = '0;
      echo_in      = '0;
      gps_wr_in    = 1'b0;
      gps_slot_in  = '0;
      frm_wr_in    = 1'b0;
      frm_slot_in  = '0;
      ip_wr_in     = 1'b0;
      ip_slot_in   = '0;

      if (req_chan.mode) begin
         // arm command: no byte processed, result stays all zero
         ip_act_in = 1'b1;
      end else begin
         echo_in = c;

         // header detection; a sentence end only counts with no header pending
         if (c == CHAR_DOLLAR && gps) begin
            hdr_state_in = HDR_DOLLAR;
         end else begin
            case (hdr_state_ff)
               HDR_DOLLAR: hdr_state_in = (c == CHAR_G && gps) ? HDR_G : HDR_IDLE;
               HDR_G:      hdr_state_in = (c == CHAR_P && gps) ? HDR_P : HDR_IDLE;
               HDR_P: begin
                  hdr_state_in = HDR_IDLE;
                  if (c == CHAR_R && gps) begin
                     gps_cap_in = 1'b1;
                     gps_pos_in = '0;
                  end
               end
               default: begin
                  if (c == CHAR_STAR && gps) begin
                     gps_cap_in           = 1'b0;
                     events_in[EV_GPS_END] = 1'b1;
                  end
               end
            endcase
         end

         if (gps_cap_in && gps && gps_pos_in < GPW'(GPS_BUF_DEPTH)) begin
            gps_wr_in   = 1'b1;
            gps_slot_in = GPS_SLOT_W'(gps_pos_in);
            gps_pos_in  = gps_pos_in + 1'b1;
         end

         if (!gps) begin
            if (c == CHAR_O) begin
               ok_half_in = 1'b1;
            end else if (ok_half_ff && c == CHAR_K) begin
               ok_half_in       = 1'b0;
               events_in[EV_OK] = 1'b1;
            end
            server_in                = server_res[MATCH_W-1:0];
            remote_in                = remote_res[MATCH_W-1:0];
            events_in[EV_SERVER_OK]  = server_res[MATCH_W];
            events_in[EV_REMOTE_IP]  = remote_res[MATCH_W];

            if (c == CHAR_DOLLAR) frm_act_in = 1'b1;
            if (frm_act_in && c != CHAR_STAR && frm_pos_ff < FPW'(FRAME_BUF_DEPTH)) begin
               frm_wr_in   = 1'b1;
               frm_slot_in = FRM_SLOT_W'(frm_pos_ff);
               frm_pos_in  = frm_pos_ff + 1'b1;
            end
            if (c == CHAR_STAR) begin
               events_in[EV_FRAME_END] = 1'b1;
               frm_act_in              = 1'b0;
               frm_pos_in              = '0;
            end
            if (c == CHAR_L) events_in[EV_LOC_REQ] = 1'b1;
         end

         if (c == CHAR_PROMPT) events_in[EV_PROMPT] = 1'b1;

         if (ip_act_ff) begin
            ip_wr_in   = 1'b1;
            ip_slot_in = ip_pos_ff;
            if (ip_next >= (IP_SLOT_W + 1)'(IP_TEXT_LEN)) begin
               ip_pos_in             = '0;
               ip_act_in             = 1'b0;
               events_in[EV_IP_DONE] = 1'b1;
            end else begin
               ip_pos_in = ip_next[IP_SLOT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gps_cap_ff <= 1'b0;
         gps_pos_ff <= '0;
         ok_half_ff <= 1'b0;
         server_ff  <= '0;
         remote_ff  <= '0;
         frm_act_ff <= 1'b0;
         frm_pos_ff <= '0;
         ip_act_ff  <= 1'b0;
         ip_pos_ff  <= '0;
      end else if (accept) begin
         gps_cap_ff <= gps_cap_in;
         gps_pos_ff <= gps_pos_in;
         ok_half_ff <= ok_half_in;
         server_ff  <= server_in;
         remote_ff  <= remote_in;
         frm_act_ff <= frm_act_in;
         frm_pos_ff <= frm_pos_in;
         ip_act_ff  <= ip_act_in;
         ip_pos_ff  <= ip_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         events_ff   <= events_in;
         echo_ff     <= echo_in;
         gps_wr_ff   <= gps_wr_in;
         gps_slot_ff <= gps_slot_in;
         frm_wr_ff   <= frm_wr_in;
         frm_slot_ff <= frm_slot_in;
         ip_wr_ff    <= ip_wr_in;
         ip_slot_ff  <= ip_slot_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.events      = events_ff;
   assign rsp_chan.echo_byte   = echo_ff;
   assign rsp_chan.gps_write   = gps_wr_ff;
   assign rsp_chan.gps_slot    = gps_slot_ff;
   assign rsp_chan.frame_write = frm_wr_ff;
   assign rsp_chan.frame_slot  = frm_slot_ff;
   assign rsp_chan.ip_write    = ip_wr_ff;
   assign rsp_chan.ip_slot     = ip_slot_ff;

endmodule
`default_nettype wire

### tb/tb_gps_and_modem_response_parser_top.sv
// Self-checking testbench for the GPS sentence / modem response parser top level.
`timescale 1ns / 1ps
module tb_gps_and_modem_response_parser_top
   import gamrp_pkg::*;
();

   localparam int GPS_DEPTH   = GPS_BUF_DEPTH_DEFAULT;
   localparam int FRAME_DEPTH = FRAME_BUF_DEPTH_DEFAULT;
   localparam int IP_LEN      = IP_TEXT_LEN_DEFAULT;
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 1750;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
      logic       gps_source;
   } uart_item_type;

   typedef struct packed {
      logic [7:0] events;
      logic [7:0] echo_byte;
      logic       gps_write;
      logic [5:0] gps_slot;
      logic       frame_write;
      logic [4:0] frame_slot;
      logic       ip_write;
      logic [3:0] ip_slot;
   } parse_result_type;

   // Tracks parser state alongside the block and holds the results still owed.
   class parse_scoreboard;
      hdr_state_type    hdr;
      logic             gps_on;
      logic [6:0]       gps_pos;
      logic             ok_seen;
      logic [7:0]       server_flags;
      logic [7:0]       remote_flags;
      logic             frame_on;
      logic [5:0]       frame_pos;
      logic             ip_on;
      logic [3:0]       ip_pos;
      parse_result_type pending_results[$];
      int               errors;
      int               reported;

      function new();
         hdr          = HDR_IDLE;
         gps_on       = 1'b0;
         gps_pos      = '0;
         ok_seen      = 1'b0;
         server_flags = '0;
         remote_flags = '0;
         frame_on     = 1'b0;
         frame_pos    = '0;
         ip_on        = 1'b0;
         ip_pos       = '0;
         errors       = 0;
         reported     = 0;
      endfunction

      // Letter chain: a letter advances only off the flag of the one before it.
      function logic step_word(input logic [0:8][7:0] word, inout logic [7:0] flags,
                               input logic [7:0] c);
         logic done;
         if (c == word[0]) flags[0] = 1'b1;
         for (int k = 1; k < 8; k++) begin
            if (c == word[k] && flags[k-1]) begin
               flags[k]   = 1'b1;
               flags[k-1] = 1'b0;
            end
         end
         done = (c == word[8]) && flags[7];
         if (done) flags[7] = 1'b0;
         return done;
      endfunction

      function parse_result_type parse_byte(input uart_item_type it);
         parse_result_type r;
         logic [7:0]       c;
         logic             gps;
         r = '0;
         if (it.mode) begin
            ip_on = 1'b1;
            return r;
         end
         c   = it.rx_byte;
         gps = it.gps_source;

         if (c == CHAR_DOLLAR && gps) begin
            hdr = HDR_DOLLAR;
         end else if (hdr == HDR_DOLLAR) begin
            hdr = (c == CHAR_G && gps) ? HDR_G : HDR_IDLE;
         end else if (hdr == HDR_G) begin
            hdr = (c == CHAR_P && gps) ? HDR_P : HDR_IDLE;
         end else if (hdr == HDR_P) begin
            hdr = HDR_IDLE;
            if (c == CHAR_R && gps) begin
               gps_on  = 1'b1;
               gps_pos = '0;
            end
         end else if (c == CHAR_STAR && gps) begin
            gps_on              = 1'b0;
            r.events[EV_GPS_END] = 1'b1;
         end

         if (gps_on && gps && gps_pos < GPS_DEPTH) begin
            r.gps_write = 1'b1;
            r.gps_slot  = gps_pos[5:0];
            gps_pos++;
         end

         if (!gps) begin
            if (c == CHAR_O) begin
               ok_seen = 1'b1;
            end else if (ok_seen && c == CHAR_K) begin
               ok_seen         = 1'b0;
               r.events[EV_OK] = 1'b1;
            end
            if (step_word(SERVER_WORD, server_flags, c)) r.events[EV_SERVER_OK] = 1'b1;
            if (step_word(REMOTE_WORD, remote_flags, c)) r.events[EV_REMOTE_IP] = 1'b1;

            if (c == CHAR_DOLLAR) frame_on = 1'b1;
            if (frame_on && c != CHAR_STAR && frame_pos < FRAME_DEPTH) begin
               r.frame_write = 1'b1;
               r.frame_slot  = frame_pos[4:0];
               frame_pos++;
            end
            if (c == CHAR_STAR) begin
               r.events[EV_FRAME_END] = 1'b1;
               frame_on               = 1'b0;
               frame_pos              = '0;
            end
         end

         if (c == CHAR_PROMPT) r.events[EV_PROMPT] = 1'b1;

         if (ip_on) begin
            r.ip_write = 1'b1;
            r.ip_slot  = ip_pos;
            ip_pos++;
            if (ip_pos >= IP_LEN) begin
               ip_pos              = '0;
               ip_on               = 1'b0;
               r.events[EV_IP_DONE] = 1'b1;
            end
         end

         if (c == CHAR_L && !gps) r.events[EV_LOC_REQ] = 1'b1;
         r.echo_byte = c;
         return r;
      endfunction

      function void note_sent(input uart_item_type it);
         pending_results.push_back(parse_byte(it));
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
         end
      endfunction

      function void check_result(input parse_result_type got);
         parse_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("%0t: result transfer with nothing outstanding", $time);
            end
            return;
         end
         want = pending_results.pop_front();
         compare_field("events", want.events, got.events);
         compare_field("echo_byte", want.echo_byte, got.echo_byte);
         compare_field("gps_write", 8'(want.gps_write), 8'(got.gps_write));
         compare_field("gps_slot", 8'(want.gps_slot), 8'(got.gps_slot));
         compare_field("frame_write", 8'(want.frame_write), 8'(got.frame_write));
         compare_field("frame_slot", 8'(want.frame_slot), 8'(got.frame_slot));
         compare_field("ip_write", 8'(want.ip_write), 8'(got.ip_write));
         compare_field("ip_slot", 8'(want.ip_slot), 8'(got.ip_slot));
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   gamrp_req_if req_chan ();
   gamrp_rsp_if rsp_chan ();

   gps_and_modem_response_parser_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   parse_scoreboard sb;
   uart_item_type   stim_q[$];
   int              tx_left = 0;
   bit              tx_quiet = 1'b0;
   int              rx_left = 0;
   bit              rx_quiet = 1'b0;
   int              idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Alternates stretches of back-to-back traffic with stretches of random gaps.
   function automatic int draw_wait(inout int left, inout bit quiet);
      if (left == 0) begin
         quiet = ($urandom_range(0, 3) == 0);
         left  = $urandom_range(20, 80);
      end
      left--;
      return quiet ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic push_item(input logic m, input logic [7:0] b, input logic g);
      uart_item_type it;
      it.mode       = m;
      it.rx_byte    = b;
      it.gps_source = g;
      stim_q.push_back(it);
   endtask

   task automatic push_text(input string s, input logic g);
      for (int k = 0; k < s.len(); k++) push_item(1'b0, s[k], g);
   endtask

   task automatic build_stimulus();
      int         len;
      logic [7:0] b;
      string      words[3];
      string      w;
      int         target;
      words = '{"OK", "SERVER OK", "REMOTE IP"};

      // directed: header and sentence end, byte extremes, broken header,
      // star while a header is pending, OK, kiosk frame, prompt, request, arm
      push_text("$GPR", 1'b1);
      push_item(1'b0, 8'h00, 1'b1);
      push_item(1'b0, 8'hFF, 1'b1);
      push_text("*", 1'b1);
      push_text("$G", 1'b1);
      push_text("P", 1'b0);
      push_text("$*", 1'b1);
      push_text("OK", 1'b0);
      push_text("$A*", 1'b0);
      push_text(">", 1'b1);
      push_text("L", 1'b0);
      push_item(1'b1, 8'hFF, 1'b1);
      push_item(1'b0, 8'hFF, 1'b0);
      push_item(1'b0, 8'h00, 1'b1);
      push_item(1'b0, 8'h00, 1'b0);
      push_text("L", 1'b1);

      target = stim_q.size() + RANDOM_ITEMS;
      while (stim_q.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               push_text("$GPR", 1'b1);
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 75)
                                                 : $urandom_range(0, 20);
               repeat (len) begin
                  if ($urandom_range(0, 15) == 0)
                     push_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                  else
                     push_item(1'b0, pick("0123456789,.ANSEWV"), 1'b1);
               end
               if ($urandom_range(0, 5) != 0) push_text("*", 1'b1);
            end
            2, 3: begin
               w = words[$urandom_range(0, 2)];
               if ($urandom_range(0, 3) == 0)
                  w[$urandom_range(0, w.len() - 1)] = pick("SERVOKMTIP ");
               push_text(w, 1'b0);
               if ($urandom_range(0, 1) != 0) push_text("\r\n", 1'b0);
            end
            4: begin
               repeat ($urandom_range(3, 12)) push_item(1'b0, pick("SERVOKMTIP "), 1'b0);
            end
            5: begin
               push_text("$", 1'b0);
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
                                                 : $urandom_range(0, 12);
               repeat (len) begin
                  do b = 8'($urandom_range(0, 255)); while (b == CHAR_STAR);
                  push_item(1'b0, b, 1'b0);
               end
               if ($urandom_range(0, 5) != 0) push_text("*", 1'b0);
            end
            6: begin
               push_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               repeat ($urandom_range(12, 20)) begin
                  if ($urandom_range(0, 19) == 0)
                     push_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                  else
                     push_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
            end
            7: begin
               push_text("$", 1'b1);
               if ($urandom_range(0, 1) != 0) push_text("G", 1'b1);
               if ($urandom_range(0, 1) != 0) push_text("P", 1'b1);
               push_item(1'b0, pick("GPR*$>"), 1'($urandom_range(0, 1)));
            end
            8: begin
               repeat ($urandom_range(1, 3))
                  push_item(1'b0, pick(">L"), 1'($urandom_range(0, 1)));
            end
            default: begin
               repeat ($urandom_range(1, 6))
                  push_item($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            end
         endcase
      end
   endtask

   task automatic send_all();
      int gap;
      foreach (stim_q[i]) begin
         gap = draw_wait(tx_left, tx_quiet);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_chan.valid      <= 1'b1;
         req_chan.mode       <= stim_q[i].mode;
         req_chan.rx_byte    <= stim_q[i].rx_byte;
         req_chan.gps_source <= stim_q[i].gps_source;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         sb.note_sent(stim_q[i]);
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain_results();
      parse_result_type got;
      int               stall;
      forever begin
         stall = draw_wait(rx_left, rx_quiet);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         got.events      = rsp_chan.events;
         got.echo_byte   = rsp_chan.echo_byte;
         got.gps_write   = rsp_chan.gps_write;
         got.gps_slot    = rsp_chan.gps_slot;
         got.frame_write = rsp_chan.frame_write;
         got.frame_slot  = rsp_chan.frame_slot;
         got.ip_write    = rsp_chan.ip_write;
         got.ip_slot     = rsp_chan.ip_slot;
         sb.check_result(got);
      end
   endtask

   // no transfer on either channel for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_gps_and_modem_response_parser_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      sb = new();
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= 1'b0;
      req_chan.rx_byte    <= 8'h00;
      req_chan.gps_source <= 1'b0;
      rsp_chan.ready      <= 1'b0;
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_results();
      join_none
      send_all();
      while (sb.pending() != 0) @(posedge clock);
      // an extra wait catches any stray result after the last expected one
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_gps_and_modem_response_parser_top: done, clean");
      else
         $display("tb_gps_and_modem_response_parser_top: done, errors");
      $finish;
   end

endmodule
